// ===== sv/cle_pkg.sv =====
`default_nettype none

package cle_pkg;

    // Size of the line buffer; at most LINE_CAPACITY-1 characters are kept.
    localparam int unsigned LINE_CAPACITY = 64;
    localparam int unsigned LINE_DEPTH    = LINE_CAPACITY - 1;
    localparam int unsigned ADDR_W        = $clog2(LINE_DEPTH);

    localparam int unsigned KEY_W    = 8;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned LIMIT_W  = 7;
    localparam int unsigned STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(LINE_CAPACITY);
    localparam logic [LIMIT_W-1:0] LIMIT_MIN = LIMIT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(LINE_DEPTH);

    // Key codes with a meaning of their own.
    localparam logic [KEY_W-1:0] KEY_NONE   = 8'd0;
    localparam logic [KEY_W-1:0] KEY_CTRL_C = 8'd3;
    localparam logic [KEY_W-1:0] KEY_BS     = 8'd8;
    localparam logic [KEY_W-1:0] KEY_LF     = 8'd10;
    localparam logic [KEY_W-1:0] KEY_CR     = 8'd13;
    localparam logic [KEY_W-1:0] KEY_SPACE  = 8'd32;
    localparam logic [KEY_W-1:0] KEY_DEL    = 8'd127;
    localparam logic [KEY_W-1:0] KEY_CARET  = 8'd94;
    localparam logic [KEY_W-1:0] KEY_UPPER_C = 8'd67;

    // Result kinds and status codes.
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CANCEL = 2'd2;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [ADDR_W-1:0]  addr_t;

endpackage

`default_nettype wire

// ===== sv/cle_ifs.sv =====
`default_nettype none

// Key channel: one key code per item.
interface cle_key_if import cle_pkg::*; ();
    logic valid;
    logic ready;
    key_t key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

// Result channel: one echo or line character per item.
interface cle_result_if import cle_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    key_t                char_value;
    logic [STATUS_W-1:0] status;
    count_t              line_length;
    logic                last;

    modport source (output valid, output kind, output char_value, output status,
                    output line_length, output last, input ready);
    modport sink   (input valid, input kind, input char_value, input status,
                    input line_length, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/console_line_editor_top.sv =====
// A printable key passes through the decode and sequencer states, and its echo item
// is then registered at the output once the output register is free. A new key is
// taken only once the sequencer is back in idle, also for a key with no item. A newline
// shows its echo, then sends each line character through the read and line states.
// Reset (rst_n, asynchronous, active low) empties the line and sets max_length to 64;
// the line store itself is not cleared, since only written entries are ever read.
`default_nettype none

module console_line_editor_top import cle_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_wdata,
    cle_key_if.sink            key,
    cle_result_if.source       result
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SEQ    = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_LINE   = 3'd4;

    // What the emitting state has to send for the current key.
    localparam logic [1:0] OP_ECHO   = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_LINE   = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [1:0] step_reg, step_next;
    key_t       key_reg;
    count_t     count_reg, count_next;
    count_t     len_reg, len_next;
    count_t     idx_reg, idx_next;
    limit_t     max_len_reg;

    // Output register; it parts the sequencer from the result channel.
    logic                out_valid_reg;
    logic                out_kind_reg, out_kind_next;
    key_t                out_char_reg, out_char_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    count_t              out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;
    logic                out_load;
    logic                out_free;

    // The one shared incrementer: it checks room for a new character, advances
    // the fill count and walks the read index through the line.
    count_t               inc_operand;
    logic [COUNT_W:0]     inc_sum;

    limit_t limit;
    key_t   key_code;
    logic   printable;
    logic   line_fin;

    logic   ram_wr_en;
    logic   ram_rd_en;
    key_t   ram_rd_data;

    // Register values outside 1..LINE_CAPACITY are pulled into that range.
    always_comb
    begin
        if (max_len_reg < LIMIT_MIN)
        begin
            limit = LIMIT_MIN;
        end
        else if (max_len_reg > LIMIT_MAX)
        begin
            limit = LIMIT_MAX;
        end
        else
        begin
            limit = max_len_reg;
        end
    end

    assign inc_operand = (state_reg == S_DECODE) ? count_reg : idx_reg;
    assign inc_sum     = {1'b0, inc_operand} + (COUNT_W + 1)'(1);

    // Carriage return is treated exactly as newline.
    assign key_code  = (key_reg == KEY_CR) ? KEY_LF : key_reg;
    assign printable = (key_code >= KEY_SPACE) && (key_code < KEY_DEL)
                       && (LIMIT_W'(inc_sum) < limit) && (count_reg < COUNT_TOP);
    assign line_fin  = (inc_sum == {1'b0, len_reg});

    assign out_free  = !out_valid_reg || result.ready;
    assign key.ready = (state_reg == S_IDLE);

    assign ram_wr_en = (state_reg == S_DECODE) && printable;
    assign ram_rd_en = (state_reg == S_READ);

    cle_ram #(
        .WIDTH (KEY_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (key_code),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        out_load        = 1'b0;
        out_kind_next   = KIND_ECHO;
        out_char_next   = key_code;
        out_status_next = STATUS_NONE;
        out_len_next    = '0;
        out_last_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (key.valid)
                begin
                    state_next = S_DECODE;
                end
            end

            // Classify the key and update the fill count before any item goes out.
            S_DECODE:
            begin
                step_next  = '0;
                state_next = S_SEQ;
                if (key_code == KEY_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (key_code == KEY_CTRL_C)
                begin
                    op_next    = OP_CANCEL;
                    count_next = '0;
                end
                else if (key_code == KEY_LF)
                begin
                    op_next    = OP_LINE;
                    len_next   = count_reg;
                    count_next = '0;
                end
                else if ((key_code inside {KEY_BS, KEY_DEL}) && (count_reg != '0))
                begin
                    op_next    = OP_ERASE;
                    count_next = count_reg - COUNT_W'(1);
                end
                else if (printable)
                begin
                    op_next    = OP_ECHO;
                    count_next = inc_sum[COUNT_W-1:0];
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // Echo items; each waits until the output register is free.
            S_SEQ:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    step_next = step_reg + 2'd1;
                    case (op_reg)
                        OP_ECHO:
                        begin
                            out_char_next = key_code;
                            out_last_next = 1'b1;
                            state_next    = S_IDLE;
                        end
                        OP_CANCEL:
                        begin
                            case (step_reg)
                                2'd0:    out_char_next = KEY_CARET;
                                2'd1:    out_char_next = KEY_UPPER_C;
                                default:
                                begin
                                    out_char_next   = KEY_LF;
                                    out_status_next = STATUS_CANCEL;
                                    out_last_next   = 1'b1;
                                    state_next      = S_IDLE;
                                end
                            endcase
                        end
                        OP_ERASE:
                        begin
                            case (step_reg)
                                2'd0:    out_char_next = KEY_BS;
                                2'd1:    out_char_next = KEY_SPACE;
                                default:
                                begin
                                    out_char_next = KEY_BS;
                                    out_last_next = 1'b1;
                                    state_next    = S_IDLE;
                                end
                            endcase
                        end
                        default:
                        begin
                            // Newline echo; an empty line ends here as done.
                            out_char_next = KEY_LF;
                            idx_next      = '0;
                            if (len_reg == '0)
                            begin
                                out_status_next = STATUS_DONE;
                                out_last_next   = 1'b1;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_LINE;
            end

            // Send one stored character; the final one carries done and the length.
            S_LINE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_LINE;
                    out_char_next = ram_rd_data;
                    if (line_fin)
                    begin
                        out_status_next = STATUS_DONE;
                        out_len_next    = len_reg;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = inc_sum[COUNT_W-1:0];
                        state_next = S_READ;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_len_reg   <= LIMIT_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        step_reg <= step_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        if (key.valid && key.ready)
        begin
            key_reg <= key.key_code;
        end
        if (out_load)
        begin
            out_kind_reg   <= out_kind_next;
            out_char_reg   <= out_char_next;
            out_status_reg <= out_status_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.char_value  = out_char_reg;
    assign result.status      = out_status_reg;
    assign result.line_length = out_len_reg;
    assign result.last        = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/cle_ram.sv =====
`default_nettype none

module cle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 63
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
